>>> sv/dll_pkg.sv
// Shared types and constants for the detector layer lookup block.
// Used by every module of the block but dll_ram; depends on nothing else.
`timescale 1ns / 1ps

package dll_pkg;

  // field widths
  localparam int VAL_W  = 18;  // table entries, radii, unsigned config limits
  localparam int Z_W    = 19;  // signed z of the point
  localparam int POS_W  = 20;  // signed search position after a shift
  localparam int DIFF_W = 21;  // distance between position and a table entry
  localparam int PL_W   = 10;  // pseudo layer
  localparam int ST_W   = 2;   // status
  localparam int ACT_W  = 2;   // action
  localparam int CIDX_W = 3;   // configuration register index

  // stream payload widths (padded to whole bytes)
  localparam int IN_TDATA_W  = 80;
  localparam int OUT_TDATA_W = 16;

  // action codes
  localparam logic [ACT_W-1:0] ACT_LOAD_BARREL = 2'd0;
  localparam logic [ACT_W-1:0] ACT_LOAD_ENDCAP = 2'd1;
  localparam logic [ACT_W-1:0] ACT_QUERY       = 2'd2;
  localparam logic [ACT_W-1:0] ACT_CLEAR       = 2'd3;

  // status codes
  localparam logic [ST_W-1:0] ST_OK        = 2'd0;
  localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [ST_W-1:0] ST_LOAD_ERR  = 2'd2;

  // configuration register indexes
  localparam logic [CIDX_W-1:0] CFG_MUON_ENDCAP_Z = 3'd0;
  localparam logic [CIDX_W-1:0] CFG_MUON_BARREL_R = 3'd1;
  localparam logic [CIDX_W-1:0] CFG_CALO_ENDCAP_Z = 3'd2;
  localparam logic [CIDX_W-1:0] CFG_CALO_BARREL_R = 3'd3;
  localparam logic [CIDX_W-1:0] CFG_CALO_R_SHIFT  = 3'd4;
  localparam logic [CIDX_W-1:0] CFG_CALO_Z_SHIFT  = 3'd5;
  localparam logic [CIDX_W-1:0] CFG_MUON_R_SHIFT  = 3'd6;
  localparam logic [CIDX_W-1:0] CFG_MUON_Z_SHIFT  = 3'd7;

  // commands from the controller to the datapath
  typedef struct packed {
    logic capture;  // input transaction taken, latch payload
    logic exec;     // run load or clear, pick regime for a query
    logic region;   // pick region, start the table searches
    logic cmp;      // one binary search step on the read data
    logic finish;   // write the result register
  } dll_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic is_query;  // latched action is a query
    logic busy;      // a table search still has steps left
  } dll_stat_t;

endpackage

>>> sv/dll_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Standalone; used for the layer tables of the lookup block.
`timescale 1ns / 1ps

module dll_ram #(
  parameter int WIDTH = 18,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

>>> sv/dll_search.sv
// One layer table: ordered load, entry count and a binary search engine.
// Depends on dll_pkg and dll_ram.
`timescale 1ns / 1ps

module dll_search #(
  parameter int DEPTH = 256
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           load_en,
  input  logic [dll_pkg::VAL_W-1:0]      load_value,
  output logic                           load_ok,
  input  logic                           clear,
  input  logic                           start,
  input  logic                           start_en,
  input  logic signed [dll_pkg::POS_W-1:0] start_pos,
  input  logic                           cmp,
  output logic                           busy,
  output logic                           found,
  output logic [$clog2(DEPTH)-1:0]       layer
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [CW-1:0]                     cnt_r, cnt_nxt;
  logic [dll_pkg::VAL_W-1:0]         last_r, last_nxt;
  logic [CW-1:0]                     lo_r, lo_nxt;
  logic [CW-1:0]                     hi_r, hi_nxt;
  logic [dll_pkg::VAL_W-1:0]         lo_val_r, lo_val_nxt;
  logic [dll_pkg::VAL_W-1:0]         hi_val_r, hi_val_nxt;
  logic signed [dll_pkg::POS_W-1:0]  pos_r, pos_nxt;
  logic                              en_r, en_nxt;
  logic [CW-1:0]                     mid;
  logic [dll_pkg::VAL_W-1:0]         rd_data;
  logic                              wr_en;
  logic                              upper;
  logic [dll_pkg::DIFF_W-1:0]        dlo;
  logic [dll_pkg::DIFF_W-1:0]        dhi;
  logic [AW-1:0]                     lo_idx;

  dll_ram #(
    .WIDTH (dll_pkg::VAL_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (cnt_r[AW-1:0]),
    .wr_data (load_value),
    .rd_addr (mid[AW-1:0]),
    .rd_data (rd_data)
  );

  // ordered-load rule: room left and strictly above the last entry
  assign load_ok = (cnt_r < CW'(DEPTH)) && ((cnt_r == '0) || (load_value > last_r));
  assign wr_en   = load_en && load_ok;

  // probe index between the search bounds
  assign mid   = lo_r + ((hi_r - lo_r) >> 1);
  assign busy  = lo_r < hi_r;
  assign upper = $signed({2'b00, rd_data}) > pos_r;

  // count and last value
  always_comb begin
    cnt_nxt  = cnt_r;
    last_nxt = last_r;
    if (clear) begin
      cnt_nxt = '0;
    end else if (wr_en) begin
      cnt_nxt  = cnt_r + 1'b1;
      last_nxt = load_value;
    end
  end

  // search bounds, with the entries that last moved each bound
  always_comb begin
    lo_nxt     = lo_r;
    hi_nxt     = hi_r;
    lo_val_nxt = lo_val_r;
    hi_val_nxt = hi_val_r;
    pos_nxt    = pos_r;
    en_nxt     = en_r;
    if (start) begin
      lo_nxt  = '0;
      hi_nxt  = start_en ? cnt_r : '0;
      pos_nxt = start_pos;
      en_nxt  = start_en;
    end else if (cmp && busy) begin
      if (upper) begin
        hi_nxt     = mid;
        hi_val_nxt = rd_data;
      end else begin
        lo_nxt     = mid + 1'b1;
        lo_val_nxt = rd_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      lo_r  <= '0;
      hi_r  <= '0;
      en_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      lo_r  <= lo_nxt;
      hi_r  <= hi_nxt;
      en_r  <= en_nxt;
    end
  end

  always_ff @(posedge clk) begin
    last_r   <= last_nxt;
    lo_val_r <= lo_val_nxt;
    hi_val_r <= hi_val_nxt;
    pos_r    <= pos_nxt;
  end

  // nearest of the bracketing entries, tie to the upper one
  assign dlo    = {pos_r[dll_pkg::POS_W-1], pos_r} - {3'b000, lo_val_r};
  assign dhi    = {3'b000, hi_val_r} - {pos_r[dll_pkg::POS_W-1], pos_r};
  assign lo_idx = lo_r[AW-1:0];
  assign found  = en_r && (lo_r < cnt_r);

  always_comb begin
    if (lo_r == '0) begin
      layer = '0;
    end else if (dlo < dhi) begin
      layer = lo_idx - 1'b1;
    end else begin
      layer = lo_idx;
    end
  end

endmodule

>>> sv/dll_ctrl.sv
// Sequencing state machine of the layer lookup block.
// Depends on dll_pkg; drives the datapath through dll_cmd_t.
`timescale 1ns / 1ps

module dll_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  output logic               out_tvalid,
  input  logic               out_tready,
  output dll_pkg::dll_cmd_t  cmd,
  input  dll_pkg::dll_stat_t stat
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_EXEC   = 3'd1;
  localparam logic [2:0] S_REGION = 3'd2;
  localparam logic [2:0] S_ISSUE  = 3'd3;
  localparam logic [2:0] S_CMP    = 3'd4;
  localparam logic [2:0] S_FIN    = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_free   = !out_valid_r || out_tready;

  // command decode
  always_comb begin
    cmd         = '0;
    cmd.capture = (state_r == S_IDLE) && in_tvalid;
    cmd.exec    = (state_r == S_EXEC);
    cmd.region  = (state_r == S_REGION);
    cmd.cmp     = (state_r == S_CMP);
    cmd.finish  = (state_r == S_FIN) && out_free;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = stat.is_query ? S_REGION : S_FIN;
      end
      S_REGION: begin
        state_nxt = S_ISSUE;
      end
      S_ISSUE: begin
        state_nxt = stat.busy ? S_CMP : S_FIN;
      end
      S_CMP: begin
        state_nxt = S_ISSUE;
      end
      S_FIN: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // result valid flag
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.finish) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

>>> sv/dll_dp.sv
// Datapath of the layer lookup block: config registers, regime and region
// choice, two table search units and the result register. Uses dll_pkg.
`timescale 1ns / 1ps

module dll_dp #(
  parameter int TABLE_DEPTH  = 256,
  parameter int LAYER_OFFSET = 1
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [dll_pkg::IN_TDATA_W-1:0]      in_tdata,
  input  logic [dll_pkg::ACT_W-1:0]           in_tuser,
  input  logic                                cfg_we,
  input  logic [dll_pkg::CIDX_W-1:0]          cfg_index,
  input  logic [dll_pkg::VAL_W-1:0]           cfg_data,
  output logic [dll_pkg::OUT_TDATA_W-1:0]     out_tdata,
  output logic [dll_pkg::ST_W-1:0]            out_tuser,
  input  dll_pkg::dll_cmd_t                   cmd,
  output dll_pkg::dll_stat_t                  stat
);

  localparam int AW    = $clog2(TABLE_DEPTH);
  localparam int VAL_W = dll_pkg::VAL_W;
  localparam int POS_W = dll_pkg::POS_W;
  localparam int Z_W   = dll_pkg::Z_W;
  localparam int PL_W  = dll_pkg::PL_W;

  // configuration registers
  logic [VAL_W-1:0] muon_ez_r, muon_br_r, calo_ez_r, calo_br_r;
  logic [VAL_W-1:0] calo_rsh_r, calo_zsh_r, muon_rsh_r, muon_zsh_r;

  // latched input transaction
  logic [dll_pkg::ACT_W-1:0] act_r;
  logic [VAL_W-1:0]          value_r;
  logic [VAL_W-1:0]          calo_r_r;
  logic [VAL_W-1:0]          muon_r_r;
  logic [Z_W-1:0]            z_r;

  // regime selection results
  logic [Z_W-1:0]   zmag, zmag_r;
  logic [VAL_W-1:0] r_sel_r, ez_sel_r, br_sel_r, rsh_sel_r, zsh_sel_r;
  logic             calo_regime;

  // region and search start
  logic                    in_barrel, in_endcap, in_overlap;
  logic signed [POS_W-1:0] pos_b, pos_e;

  // load status and result
  logic [dll_pkg::ST_W-1:0] load_st_r, load_st_nxt;
  logic [PL_W-1:0]          out_pl_r, out_pl_nxt;
  logic [dll_pkg::ST_W-1:0] out_st_r, out_st_nxt;

  // search unit signals
  logic          load_b, load_e, ok_b, ok_e, clear;
  logic          busy_b, busy_e, found_b, found_e;
  logic [AW-1:0] layer_b, layer_e, lay_b_eff, lay_e_eff, lay_max;
  logic          query_ok;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      muon_ez_r  <= '0;
      muon_br_r  <= '0;
      calo_ez_r  <= '0;
      calo_br_r  <= '0;
      calo_rsh_r <= '0;
      calo_zsh_r <= '0;
      muon_rsh_r <= '0;
      muon_zsh_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        dll_pkg::CFG_MUON_ENDCAP_Z: muon_ez_r  <= cfg_data;
        dll_pkg::CFG_MUON_BARREL_R: muon_br_r  <= cfg_data;
        dll_pkg::CFG_CALO_ENDCAP_Z: calo_ez_r  <= cfg_data;
        dll_pkg::CFG_CALO_BARREL_R: calo_br_r  <= cfg_data;
        dll_pkg::CFG_CALO_R_SHIFT:  calo_rsh_r <= cfg_data;
        dll_pkg::CFG_CALO_Z_SHIFT:  calo_zsh_r <= cfg_data;
        dll_pkg::CFG_MUON_R_SHIFT:  muon_rsh_r <= cfg_data;
        dll_pkg::CFG_MUON_Z_SHIFT:  muon_zsh_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // latch the input transaction
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      act_r    <= in_tuser;
      value_r  <= in_tdata[17:0];
      calo_r_r <= in_tdata[35:18];
      muon_r_r <= in_tdata[53:36];
      z_r      <= in_tdata[72:54];
    end
  end

  // regime: calorimeter inside the muon system, muon otherwise
  assign zmag        = z_r[Z_W-1] ? (~z_r + 1'b1) : z_r;
  assign calo_regime = (zmag < {1'b0, muon_ez_r}) && (muon_r_r < muon_br_r);

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      zmag_r <= zmag;
      if (calo_regime) begin
        r_sel_r   <= calo_r_r;
        ez_sel_r  <= calo_ez_r;
        br_sel_r  <= calo_br_r;
        rsh_sel_r <= calo_rsh_r;
        zsh_sel_r <= calo_zsh_r;
      end else begin
        r_sel_r   <= muon_r_r;
        ez_sel_r  <= muon_ez_r;
        br_sel_r  <= muon_br_r;
        rsh_sel_r <= muon_rsh_r;
        zsh_sel_r <= muon_zsh_r;
      end
    end
  end

  // region and shifted search positions
  assign in_barrel  = zmag_r < {1'b0, ez_sel_r};
  assign in_endcap  = !in_barrel && (r_sel_r < br_sel_r);
  assign in_overlap = !in_barrel && !in_endcap;

  always_comb begin
    pos_b = signed'({2'b00, r_sel_r});
    pos_e = signed'({1'b0, zmag_r});
    if (in_overlap) begin
      pos_b = signed'({2'b00, r_sel_r} - {{2{rsh_sel_r[VAL_W-1]}}, rsh_sel_r});
      pos_e = signed'({1'b0, zmag_r} - {{2{zsh_sel_r[VAL_W-1]}}, zsh_sel_r});
    end
  end

  // load and clear decode
  assign load_b = cmd.exec && (act_r == dll_pkg::ACT_LOAD_BARREL);
  assign load_e = cmd.exec && (act_r == dll_pkg::ACT_LOAD_ENDCAP);
  assign clear  = cmd.exec && (act_r == dll_pkg::ACT_CLEAR);

  dll_search #(
    .DEPTH (TABLE_DEPTH)
  ) u_barrel (
    .clk        (clk),
    .rst_n      (rst_n),
    .load_en    (load_b),
    .load_value (value_r),
    .load_ok    (ok_b),
    .clear      (clear),
    .start      (cmd.region),
    .start_en   (in_barrel || in_overlap),
    .start_pos  (pos_b),
    .cmp        (cmd.cmp),
    .busy       (busy_b),
    .found      (found_b),
    .layer      (layer_b)
  );

  dll_search #(
    .DEPTH (TABLE_DEPTH)
  ) u_endcap (
    .clk        (clk),
    .rst_n      (rst_n),
    .load_en    (load_e),
    .load_value (value_r),
    .load_ok    (ok_e),
    .clear      (clear),
    .start      (cmd.region),
    .start_en   (in_endcap || in_overlap),
    .start_pos  (pos_e),
    .cmp        (cmd.cmp),
    .busy       (busy_e),
    .found      (found_e),
    .layer      (layer_e)
  );

  // load outcome, held until the result is written
  always_comb begin
    load_st_nxt = load_st_r;
    if (cmd.exec) begin
      load_st_nxt = dll_pkg::ST_OK;
      if ((load_b && !ok_b) || (load_e && !ok_e)) begin
        load_st_nxt = dll_pkg::ST_LOAD_ERR;
      end
    end
  end

  always_ff @(posedge clk) begin
    load_st_r <= load_st_nxt;
  end

  // larger layer of the searches that hit; a miss counts as layer zero
  assign lay_b_eff = found_b ? layer_b : '0;
  assign lay_e_eff = found_e ? layer_e : '0;
  assign lay_max   = (lay_b_eff > lay_e_eff) ? lay_b_eff : lay_e_eff;
  assign query_ok  = found_b || found_e;

  always_comb begin
    out_pl_nxt = out_pl_r;
    out_st_nxt = out_st_r;
    if (cmd.finish) begin
      if (act_r == dll_pkg::ACT_QUERY) begin
        if (query_ok) begin
          out_pl_nxt = PL_W'(LAYER_OFFSET) + PL_W'(lay_max);
          out_st_nxt = dll_pkg::ST_OK;
        end else begin
          out_pl_nxt = '0;
          out_st_nxt = dll_pkg::ST_NOT_FOUND;
        end
      end else begin
        out_pl_nxt = '0;
        out_st_nxt = load_st_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_pl_r <= out_pl_nxt;
    out_st_r <= out_st_nxt;
  end

  assign out_tdata = {{(dll_pkg::OUT_TDATA_W - PL_W){1'b0}}, out_pl_r};
  assign out_tuser = out_st_r;

  assign stat.is_query = (act_r == dll_pkg::ACT_QUERY);
  assign stat.busy     = busy_b || busy_e;

endmodule

>>> sv/detector_layer_lookup.sv
// Top level of the detector pseudo-layer lookup block.
// Depends on dll_pkg, dll_ctrl, dll_dp (and through it dll_search, dll_ram).
`timescale 1ns / 1ps

// Keeps a barrel and an endcap table of layer distances (1/16 mm), each
// loaded in strictly ascending order; a load that is not above the last
// entry or that finds the table full is dropped with status 2, and a clear
// empties both tables. A query picks the calorimeter or muon regime, then
// the barrel, endcap or overlap region, binary-searches the table(s) for the
// nearest layer (ties to the upper entry) and returns LAYER_OFFSET plus the
// layer, or status 1 when nothing is found. One item is worked on at a time
// and gives exactly one result transaction. A load or clear passes through
// the exec and finish states; a query passes through exec, region, the
// search steps and finish, and its number of search steps follows the entry
// count of the larger table searched. Each search step passes through an
// issue and a compare state because the table RAM has a registered read
// port, and in the overlap region both tables are searched side by side.
// The next item is taken once the result sits in the output register.
// Configuration writes are accepted every cycle.
module detector_layer_lookup #(
  parameter int TABLE_DEPTH  = 256,
  parameter int LAYER_OFFSET = 1
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // input stream
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // table_value[17:0], calo_radius[35:18], muon_radius[53:36],
  // z_position[72:54], zero fill [79:73]
  input  logic [dll_pkg::IN_TDATA_W-1:0]      in_tdata,
  // action[1:0]
  input  logic [dll_pkg::ACT_W-1:0]           in_tuser,
  // result stream
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // pseudo_layer[9:0], zero fill [15:10]
  output logic [dll_pkg::OUT_TDATA_W-1:0]     out_tdata,
  // status[1:0]
  output logic [dll_pkg::ST_W-1:0]            out_tuser,
  // configuration write channel
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [dll_pkg::CIDX_W-1:0]          cfg_index,
  input  logic [dll_pkg::VAL_W-1:0]           cfg_data
);

  dll_pkg::dll_cmd_t  cmd;
  dll_pkg::dll_stat_t stat;

  assign cfg_ready = 1'b1;

  dll_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .stat       (stat)
  );

  dll_dp #(
    .TABLE_DEPTH  (TABLE_DEPTH),
    .LAYER_OFFSET (LAYER_OFFSET)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule

>>> tb/detector_layer_lookup_tb.sv
// Self-checking testbench for detector_layer_lookup: directed and random table loads,
// clears and queries under random idling on both streams, with a scoreboard class.
// Depends on dll_pkg and the detector_layer_lookup RTL only.
`timescale 1ns / 1ps

localparam int TABLE_DEPTH  = 256;
localparam int LAYER_OFFSET = 1;
localparam int COORD_MAX    = (1 << dll_pkg::VAL_W) - 1;
localparam int SHIFT_MIN    = -(1 << (dll_pkg::VAL_W - 1));
localparam int SHIFT_MAX    = (1 << (dll_pkg::VAL_W - 1)) - 1;

typedef struct {
  logic [dll_pkg::ACT_W-1:0]      action;
  logic [dll_pkg::VAL_W-1:0]      table_value;
  logic [dll_pkg::VAL_W-1:0]      calo_radius;
  logic [dll_pkg::VAL_W-1:0]      muon_radius;
  logic signed [dll_pkg::Z_W-1:0] z_position;
} lookup_item_t;

typedef struct {
  logic [dll_pkg::PL_W-1:0] pseudo_layer;
  logic [dll_pkg::ST_W-1:0] status;
} layer_result_t;

// geometry register sets used across the run
typedef enum {GEO_ZERO, GEO_FULL, GEO_TYPICAL} geo_kind_t;

// tracks the tables and registers, predicts each result and checks the outputs
class layer_tracker;
  logic [dll_pkg::VAL_W-1:0] geo [1 << dll_pkg::CIDX_W];
  bit [dll_pkg::VAL_W-1:0]   barrel_tab [TABLE_DEPTH];
  bit [dll_pkg::VAL_W-1:0]   endcap_tab [TABLE_DEPTH];
  int                        barrel_cnt;
  int                        endcap_cnt;
  layer_result_t             awaited [$];
  int mismatches, checked, n_loads, n_rejected, n_queries, n_missed, n_clears;

  function new();
    foreach (geo[i]) geo[i] = '0;
    barrel_cnt = 0;
    endcap_cnt = 0;
    mismatches = 0;
    checked    = 0;
    n_loads    = 0;
    n_rejected = 0;
    n_queries  = 0;
    n_missed   = 0;
    n_clears   = 0;
  endfunction

  function void set_reg(logic [dll_pkg::CIDX_W-1:0] idx, logic [dll_pkg::VAL_W-1:0] data);
    geo[idx] = data;
  endfunction

  function int shift_of(logic [dll_pkg::CIDX_W-1:0] idx);
    return int'($signed(geo[idx]));
  endfunction

  function int tab_value(bit in_barrel, int i);
    return in_barrel ? int'(barrel_tab[i]) : int'(endcap_tab[i]);
  endfunction

  // append in strictly ascending order, refuse when full
  function bit append(bit in_barrel, logic [dll_pkg::VAL_W-1:0] v);
    if (in_barrel) begin
      if (barrel_cnt >= TABLE_DEPTH || (barrel_cnt > 0 && v <= barrel_tab[barrel_cnt-1]))
        return 1'b0;
      barrel_tab[barrel_cnt] = v;
      barrel_cnt++;
    end else begin
      if (endcap_cnt >= TABLE_DEPTH || (endcap_cnt > 0 && v <= endcap_tab[endcap_cnt-1]))
        return 1'b0;
      endcap_tab[endcap_cnt] = v;
      endcap_cnt++;
    end
    return 1'b1;
  endfunction

  // first entry above pos, then the nearer neighbor; ties go to the upper entry
  function bit nearest(int pos, bit in_barrel, output int layer);
    int lo, hi, mid, cnt, dlo, dhi;
    cnt = in_barrel ? barrel_cnt : endcap_cnt;
    lo = 0;
    hi = cnt;
    layer = 0;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (tab_value(in_barrel, mid) > pos) hi = mid;
      else lo = mid + 1;
    end
    if (lo >= cnt) return 1'b0;
    if (lo == 0) return 1'b1;
    dlo = pos - tab_value(in_barrel, lo - 1);
    dhi = tab_value(in_barrel, lo) - pos;
    layer = (dlo < dhi) ? lo - 1 : lo;
    return 1'b1;
  endfunction

  // note an accepted input transaction and queue the result it must give
  function void take_item(lookup_item_t it);
    layer_result_t res;
    int  zmag, r, endcap_z, barrel_r, rshift, zshift, lb, le, layer;
    bit  ok_b, ok_e, ok;
    res.pseudo_layer = '0;
    res.status       = dll_pkg::ST_OK;
    case (it.action)
      dll_pkg::ACT_LOAD_BARREL, dll_pkg::ACT_LOAD_ENDCAP: begin
        n_loads++;
        if (!append(it.action == dll_pkg::ACT_LOAD_BARREL, it.table_value)) begin
          res.status = dll_pkg::ST_LOAD_ERR;
          n_rejected++;
        end
      end
      dll_pkg::ACT_CLEAR: begin
        barrel_cnt = 0;
        endcap_cnt = 0;
        n_clears++;
      end
      default: begin
        n_queries++;
        zmag = int'(it.z_position);
        if (zmag < 0) zmag = -zmag;
        // calorimeter regime inside the muon system, muon regime outside
        if (zmag < int'(geo[dll_pkg::CFG_MUON_ENDCAP_Z]) &&
            int'(it.muon_radius) < int'(geo[dll_pkg::CFG_MUON_BARREL_R])) begin
          r        = int'(it.calo_radius);
          endcap_z = int'(geo[dll_pkg::CFG_CALO_ENDCAP_Z]);
          barrel_r = int'(geo[dll_pkg::CFG_CALO_BARREL_R]);
          rshift   = shift_of(dll_pkg::CFG_CALO_R_SHIFT);
          zshift   = shift_of(dll_pkg::CFG_CALO_Z_SHIFT);
        end else begin
          r        = int'(it.muon_radius);
          endcap_z = int'(geo[dll_pkg::CFG_MUON_ENDCAP_Z]);
          barrel_r = int'(geo[dll_pkg::CFG_MUON_BARREL_R]);
          rshift   = shift_of(dll_pkg::CFG_MUON_R_SHIFT);
          zshift   = shift_of(dll_pkg::CFG_MUON_Z_SHIFT);
        end
        // region: barrel, endcap or overlap
        if (zmag < endcap_z) begin
          ok = nearest(r, 1'b1, layer);
        end else if (r < barrel_r) begin
          ok = nearest(zmag, 1'b0, layer);
        end else begin
          ok_b  = nearest(r - rshift, 1'b1, lb);
          ok_e  = nearest(zmag - zshift, 1'b0, le);
          ok    = ok_b || ok_e;
          layer = (lb > le) ? lb : le;
        end
        if (ok) begin
          res.pseudo_layer = dll_pkg::PL_W'(LAYER_OFFSET + layer);
        end else begin
          res.status = dll_pkg::ST_NOT_FOUND;
          n_missed++;
        end
      end
    endcase
    awaited = {awaited, res};
  endfunction

  // compare one result transaction with the oldest prediction
  function void check_result(logic [dll_pkg::PL_W-1:0] layer,
                             logic [dll_pkg::ST_W-1:0] st);
    layer_result_t want;
    checked++;
    if (awaited.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: result with nothing pending: layer=%0d status=%0d", $time, layer, st);
      return;
    end
    want = awaited.pop_front();
    if (layer !== want.pseudo_layer || st !== want.status) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: mismatch: expected layer=%0d status=%0d, got layer=%0d status=%0d",
                 $time, want.pseudo_layer, want.status, layer, st);
    end
  endfunction
endclass

module detector_layer_lookup_tb;

  logic                            clk        = 1'b0;
  logic                            rst_n      = 1'b0;
  logic                            in_tvalid  = 1'b0;
  logic                            in_tready;
  logic [dll_pkg::IN_TDATA_W-1:0]  in_tdata   = '0;
  logic [dll_pkg::ACT_W-1:0]       in_tuser   = '0;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [dll_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic [dll_pkg::ST_W-1:0]        out_tuser;
  logic                            cfg_valid  = 1'b0;
  logic                            cfg_ready;
  logic [dll_pkg::CIDX_W-1:0]      cfg_index  = '0;
  logic [dll_pkg::VAL_W-1:0]       cfg_data   = '0;

  layer_tracker sb;
  int send_idle_pct = 29;
  int recv_idle_pct = 51;
  int n_sent        = 0;
  int n_settings    = 0;

  detector_layer_lookup #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .LAYER_OFFSET(LAYER_OFFSET)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // receiver stalls at random
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // every result transaction goes to the scoreboard
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_result(out_tdata[dll_pkg::PL_W-1:0], out_tuser);
  end

  // run limit
  initial begin
    #(10_000_000);
    $display("detector_layer_lookup_tb NOT OK");
    $finish;
  end

  function automatic int random_coord();
    return int'($urandom_range(COORD_MAX));
  endfunction

  function automatic int random_z();
    return int'($urandom_range(2 * COORD_MAX)) - COORD_MAX;
  endfunction

  function automatic int random_shift();
    if ($urandom_range(3) == 0) return int'($urandom_range(COORD_MAX)) + SHIFT_MIN;
    return int'($urandom_range(8000)) - 4000;
  endfunction

  // coordinate near the interesting points: entries, midpoints, limits, shifted entries, extremes
  function automatic int pick_coord(int lim_a, int lim_b, int shift);
    int v, n, i;
    bit from_barrel;
    from_barrel = 1'($urandom_range(1));
    n = from_barrel ? sb.barrel_cnt : sb.endcap_cnt;
    v = random_coord();
    case ($urandom_range(7))
      2: if (n > 0)
           v = sb.tab_value(from_barrel, int'($urandom_range(n - 1))) +
               int'($urandom_range(4)) - 2;
      3: if (n > 1) begin
           i = int'($urandom_range(n - 2));
           v = (sb.tab_value(from_barrel, i) + sb.tab_value(from_barrel, i + 1)) / 2 +
               int'($urandom_range(1));
         end
      4: v = lim_a + int'($urandom_range(2)) - 1;
      5: v = lim_b + int'($urandom_range(2)) - 1;
      6: if (n > 0)
           v = sb.tab_value(from_barrel, int'($urandom_range(n - 1))) + shift +
               int'($urandom_range(2)) - 1;
      7: v = $urandom_range(1) ? 0 : COORD_MAX;
      default: ;
    endcase
    if (v < 0) v = 0;
    else if (v > COORD_MAX) v = COORD_MAX;
    return v;
  endfunction

  // one input transaction, with a random gap in front
  task automatic send_item(input logic [dll_pkg::ACT_W-1:0] action, input int value,
                           input int calo, input int muon, input int z);
    lookup_item_t it;
    it.action      = action;
    it.table_value = dll_pkg::VAL_W'(value);
    it.calo_radius = dll_pkg::VAL_W'(calo);
    it.muon_radius = dll_pkg::VAL_W'(muon);
    it.z_position  = dll_pkg::Z_W'(z);
    if ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= it.action;
    in_tdata  <= {7'd0, it.z_position, it.muon_radius, it.calo_radius, it.table_value};
    do @(posedge clk); while (!in_tready);
    sb.take_item(it);
    n_sent++;
  endtask

  // hold off the sender until every pending result is out
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (sb.awaited.size() != 0);
  endtask

  task automatic write_reg(input logic [dll_pkg::CIDX_W-1:0] idx, input int value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= dll_pkg::VAL_W'(value);
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, dll_pkg::VAL_W'(value));
  endtask

  task automatic apply_setting(input int mez, input int mbr, input int cez, input int cbr,
                               input int crs, input int czs, input int mrs, input int mzs);
    write_reg(dll_pkg::CFG_MUON_ENDCAP_Z, mez);
    write_reg(dll_pkg::CFG_MUON_BARREL_R, mbr);
    write_reg(dll_pkg::CFG_CALO_ENDCAP_Z, cez);
    write_reg(dll_pkg::CFG_CALO_BARREL_R, cbr);
    write_reg(dll_pkg::CFG_CALO_R_SHIFT, crs);
    write_reg(dll_pkg::CFG_CALO_Z_SHIFT, czs);
    write_reg(dll_pkg::CFG_MUON_R_SHIFT, mrs);
    write_reg(dll_pkg::CFG_MUON_Z_SHIFT, mzs);
    cfg_valid <= 1'b0;
    n_settings++;
  endtask

  task automatic choose_setting(input geo_kind_t kind);
    int mez, mbr;
    case (kind)
      GEO_ZERO: apply_setting(0, 0, 0, 0, SHIFT_MAX, SHIFT_MIN, SHIFT_MAX, SHIFT_MIN);
      GEO_FULL: apply_setting(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
                              SHIFT_MIN, SHIFT_MAX, SHIFT_MIN, SHIFT_MAX);
      default: begin
        // nested detector: calorimeter limits inside the muon limits
        mez = int'($urandom_range(COORD_MAX, 120000));
        mbr = int'($urandom_range(COORD_MAX, 100000));
        apply_setting(mez, mbr, int'($urandom_range(mez)), int'($urandom_range(mbr)),
                      random_shift(), random_shift(), random_shift(), random_shift());
      end
    endcase
  endtask

  task automatic send_query();
    int zmag, calo, muon;
    calo = pick_coord(int'(sb.geo[dll_pkg::CFG_CALO_BARREL_R]),
                      int'(sb.geo[dll_pkg::CFG_MUON_BARREL_R]),
                      sb.shift_of(dll_pkg::CFG_CALO_R_SHIFT));
    muon = pick_coord(int'(sb.geo[dll_pkg::CFG_MUON_BARREL_R]),
                      int'(sb.geo[dll_pkg::CFG_CALO_BARREL_R]),
                      sb.shift_of(dll_pkg::CFG_MUON_R_SHIFT));
    zmag = pick_coord(int'(sb.geo[dll_pkg::CFG_MUON_ENDCAP_Z]),
                      int'(sb.geo[dll_pkg::CFG_CALO_ENDCAP_Z]),
                      $urandom_range(1) ? sb.shift_of(dll_pkg::CFG_CALO_Z_SHIFT)
                                        : sb.shift_of(dll_pkg::CFG_MUON_Z_SHIFT));
    send_item(dll_pkg::ACT_QUERY, random_coord(), calo, muon,
              $urandom_range(1) ? -zmag : zmag);
  endtask

  // ascending loads with small and large steps, now and then a duplicate or a step back
  task automatic load_run(input bit to_barrel, input int n);
    int i, cnt, last, v;
    for (i = 0; i < n; i++) begin
      cnt  = to_barrel ? sb.barrel_cnt : sb.endcap_cnt;
      last = (cnt > 0) ? sb.tab_value(to_barrel, cnt - 1) : -1;
      if (cnt > 0 && $urandom_range(11) == 0) begin
        v = last - int'($urandom_range(3));
        if (v < 0) v = 0;
      end else begin
        case ($urandom_range(3))
          0: v = 1;
          1: v = 2;
          2: v = int'($urandom_range(64, 1));
          default: v = int'($urandom_range((n > 20) ? 900 : 40000, 1));
        endcase
        v = (last < 0) ? int'($urandom_range(3000)) : last + v;
        if (v > COORD_MAX) v = COORD_MAX;
      end
      send_item(to_barrel ? dll_pkg::ACT_LOAD_BARREL : dll_pkg::ACT_LOAD_ENDCAP, v,
                random_coord(), random_coord(), random_z());
    end
  endtask

  // clear unless skipped at random, fill both tables, then query them
  task automatic run_batch(input int nb, input int ne);
    if (nb > 20 || ne > 20 || $urandom_range(3) != 0)
      send_item(dll_pkg::ACT_CLEAR, random_coord(), random_coord(), random_coord(),
                random_z());
    load_run(1'b1, nb);
    load_run(1'b0, ne);
    repeat ($urandom_range(24, 4)) send_query();
  endtask

  task automatic run_random_phase(input int quota, input int fill_b, input int fill_e);
    int first;
    first = n_sent;
    while (n_sent - first < quota) begin
      if (fill_b == 0 && fill_e == 0 && $urandom_range(9) == 0) begin
        // unstructured transaction
        send_item(dll_pkg::ACT_W'($urandom_range(3)), random_coord(), random_coord(),
                  random_coord(), random_z());
      end else begin
        run_batch(fill_b > 0 ? fill_b : int'($urandom_range(12)),
                  fill_e > 0 ? fill_e : int'($urandom_range(12)));
        fill_b = 0;
        fill_e = 0;
      end
      if ($urandom_range(11) == 0) wait_drained();
    end
  endtask

  initial begin
    int p;
    sb = new();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed part on a small hand-made geometry
    apply_setting(160000, 120000, 40000, 30000, 100, -100, -50, 75);
    send_item(dll_pkg::ACT_QUERY, 0, 0, 0, 0);                    // empty tables
    send_item(dll_pkg::ACT_LOAD_BARREL, 1000, 0, 0, 0);
    send_item(dll_pkg::ACT_LOAD_BARREL, 2000, 0, 0, 0);
    send_item(dll_pkg::ACT_LOAD_BARREL, 2000, 0, 0, 0);           // duplicate
    send_item(dll_pkg::ACT_LOAD_BARREL, 1500, 0, 0, 0);           // out of order
    send_item(dll_pkg::ACT_LOAD_BARREL, 4000, 0, 0, 0);
    send_item(dll_pkg::ACT_LOAD_ENDCAP, 50000, 0, 0, 0);
    send_item(dll_pkg::ACT_LOAD_ENDCAP, 60000, 0, 0, 0);
    send_item(dll_pkg::ACT_LOAD_ENDCAP, 70000, 0, 0, 0);
    send_item(dll_pkg::ACT_QUERY, COORD_MAX, 1500, 0, 0);         // tie goes up
    send_item(dll_pkg::ACT_QUERY, 0, 1499, 0, 0);                 // nearer lower entry
    send_item(dll_pkg::ACT_QUERY, 0, 0, 0, 0);                    // below first entry
    send_item(dll_pkg::ACT_QUERY, 0, 4000, 0, 0);                 // equal to last entry
    send_item(dll_pkg::ACT_QUERY, 0, 10000, 0, -55000);           // endcap tie, negative z
    send_item(dll_pkg::ACT_QUERY, 0, 35000, 0, 45000);            // overlap, endcap only
    send_item(dll_pkg::ACT_QUERY, 0, 35000, 0, 80000);            // overlap, neither side
    send_item(dll_pkg::ACT_QUERY, 0, 0, 130000, 200000);          // muon regime overlap
    send_item(dll_pkg::ACT_QUERY, COORD_MAX, COORD_MAX, COORD_MAX, -COORD_MAX);
    send_item(dll_pkg::ACT_QUERY, 0, 0, 0, COORD_MAX);            // muon regime endcap
    send_item(dll_pkg::ACT_CLEAR, 0, 0, 0, 0);
    send_item(dll_pkg::ACT_QUERY, 0, 1500, 0, 0);                 // after clear
    send_item(dll_pkg::ACT_LOAD_BARREL, 0, 0, 0, 0);
    send_item(dll_pkg::ACT_LOAD_BARREL, COORD_MAX, 0, 0, 0);
    send_item(dll_pkg::ACT_LOAD_BARREL, COORD_MAX, 0, 0, 0);      // duplicate at the top
    send_item(dll_pkg::ACT_QUERY, 0, 131071, 0, 0);

    // random phases: register set and idling change between phases
    for (p = 0; p < 6; p++) begin
      wait_drained();
      case (p)
        1, 5:    choose_setting(GEO_FULL);
        2:       choose_setting(GEO_ZERO);
        default: choose_setting(GEO_TYPICAL);
      endcase
      if (p < 2) begin
        send_idle_pct = 29;
        recv_idle_pct = 51;
      end else if (p < 4) begin
        send_idle_pct = 51;
        recv_idle_pct = 29;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      run_random_phase(170, (p == 1) ? 300 : 0, (p == 4) ? 300 : 0);
    end

    wait_drained();
    repeat (40) @(posedge clk);
    $display("run covered %0d transactions: %0d loads (%0d refused),", n_sent,
             sb.n_loads, sb.n_rejected);
    $display("%0d queries (%0d not found), %0d clears, %0d results checked",
             sb.n_queries, sb.n_missed, sb.n_clears, sb.checked);
    $display("under %0d register sets, %0d mismatches", n_settings, sb.mismatches);
    if (sb.awaited.size() != 0)
      $display("%0d predicted results never arrived", sb.awaited.size());
    if (sb.mismatches == 0 && sb.awaited.size() == 0) begin
      $display("detector_layer_lookup_tb OK");
    end else begin
      $display("detector_layer_lookup_tb NOT OK");
    end
    $finish;
  end

endmodule
